// File: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/fpl_pkg.sv
// Package: types and constants of the four-pole ladder low-pass filter
package fpl_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ResW    = 15;
  localparam int unsigned AccW    = 32;
  localparam int unsigned ProdW   = 2 * AccW;

  localparam logic [AccW-1:0] CoefOffset = 32'h4000_0000;
  localparam logic [AccW-1:0] BlendQ31   = 32'h7df3_b644;
  localparam logic signed [AccW-1:0] ClipLimitPos = 32'sh0100_0000;
  localparam logic signed [AccW-1:0] ClipLimitNeg = -32'sh0100_0000;
  localparam logic [AccW-1:0] ClipValuePos = 32'h00ff_ffff;
  localparam logic [AccW-1:0] ClipValueNeg = 32'hff00_0001;

  localparam int unsigned AudioShift = 14;
  localparam int unsigned CoefShift  = 15;
  localparam int unsigned ResShift   = 16;
  localparam int unsigned FbShift    = 3;

  typedef logic [2:0] step_t;
  localparam step_t StepRes   = 3'd0;
  localparam step_t StepBlend = 3'd1;
  localparam step_t StepLast  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } fpl_state_e;

endpackage

// File: design/fpl_mul.sv
// Shared signed 32x32 multiplier with registered product
module fpl_mul import fpl_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [AccW-1:0]  a_i,
  input  logic signed [AccW-1:0]  b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: design/four_pole_ladder_lowpass_core.sv
// Top level: four-pole ladder low-pass filter on one shared multiplier
//
//  port group  | dir | word
//  s_axis      | in  | audio_in [15:0], cutoff_control [31:16]
//  m_axis      | out | audio_out [15:0]
//  cfg         | in  | resonance_amount [14:0]
//
// Six products per sample on one registered multiplier, each in the steps
// operand (ST_PREP), multiply (ST_MUL) and accumulate (ST_ACC); a new sample
// is taken only in ST_IDLE, after ST_DONE has loaded the last result.
// The four stages rotate through one fixed slot, so each pole step is alike.
// rst_ni clears the stages, the resonance and the handshake state.
// A waiting result does not block the next sample; the next result waits in ST_DONE.
module four_pole_ladder_lowpass_core import fpl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // audio_in, cutoff_control
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // audio_out
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ResW-1:0]      cfg_data_i
);

  fpl_state_e state_q, state_d;
  step_t      step_q, step_d;

  logic [ResW-1:0] res_q;
  logic [AccW-1:0] v_q, v_d;
  logic [AccW-1:0] coef_q, coef_d;
  logic [AccW-1:0] stg_q [4];
  logic [AccW-1:0] stg_d [4];
  logic [AccW-1:0] op_a_q, op_a_d, op_b_q, op_b_d;
  logic            out_valid_q, out_valid_d;
  logic [SampleW-1:0] out_data_q, out_data_d;

  logic signed [ProdW-1:0] prod;
  logic [AccW-1:0] clipped;
  logic [AccW-1:0] new_stage;
  logic [AccW-1:0] x_ext, c_ext;

  fpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a_q),
    .b_i   (op_b_q),
    .p_o   (prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  assign x_ext = {{(AccW-SampleW){s_axis_tdata[SampleW-1]}}, s_axis_tdata[SampleW-1:0]};
  assign c_ext = {{(AccW-SampleW){s_axis_tdata[2*SampleW-1]}},
                  s_axis_tdata[2*SampleW-1:SampleW]};

  always_comb begin
    priority if ($signed(v_q) >= ClipLimitPos) begin
      clipped = ClipValuePos;
    end else if ($signed(v_q) <= ClipLimitNeg) begin
      clipped = ClipValueNeg;
    end else begin
      clipped = v_q;
    end
  end

  assign new_stage = stg_q[0] + prod[ProdW-1:AccW];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    v_d         = v_q;
    coef_d      = coef_q;
    stg_d       = stg_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          v_d     = x_ext << AudioShift;
          coef_d  = (c_ext << CoefShift) + CoefOffset;
          step_d  = StepRes;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        priority if (step_q == StepRes) begin
          op_a_d = stg_q[3] - v_q;
          op_b_d = {{(AccW-ResW-ResShift){1'b0}}, res_q, {ResShift{1'b0}}};
        end else if (step_q == StepBlend) begin
          op_a_d = clipped - v_q;
          op_b_d = BlendQ31;
        end else begin
          op_a_d = v_q - stg_q[0];
          op_b_d = coef_q;
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        priority if (step_q == StepRes) begin
          v_d = v_q - (prod[ProdW-1:AccW] << FbShift);
        end else if (step_q == StepBlend) begin
          v_d = v_q + prod[ProdW-2:AccW-1];
        end else begin
          v_d      = new_stage;
          stg_d[0] = stg_q[1];
          stg_d[1] = stg_q[2];
          stg_d[2] = stg_q[3];
          stg_d[3] = new_stage;
        end
        if (step_q == StepLast) begin
          state_d = ST_DONE;
        end else begin
          step_d  = step_q + step_t'(1);
          state_d = ST_PREP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = stg_q[3][AudioShift+SampleW-1:AudioShift];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepRes;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        stg_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      stg_q       <= stg_d;
      if (cfg_valid_i && cfg_ready_o) begin
        res_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    coef_q     <= coef_d;
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: design/fpl_checker.sv
// Port-level checker for the ladder filter core, bound to the top level
`include "assert_macros.svh"

module fpl_checker import fpl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [15:0]          m_axis_tdata,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);

  logic in_word;
  assign in_word = s_axis_tvalid && s_axis_tready;

  `ASSERT_NEXT(busy_after_word, clk_i, rst_ni, in_word, !s_axis_tready)
  `ASSERT_NEXT(no_result_too_soon, clk_i, rst_ni, in_word, !$rose(m_axis_tvalid))
  `ASSERT_NEXT(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_SAME(cfg_always_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind four_pole_ladder_lowpass_core fpl_checker u_fpl_checker (.*);
